### design/interval_max_overlap_defines.svh
// assertion macros for the interval overlap block
`ifndef INTERVAL_MAX_OVERLAP_DEFINES_SVH
`define INTERVAL_MAX_OVERLAP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define IMO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("imo assertion failed");

// condition must never be true out of reset
`define IMO_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("imo forbidden condition seen");

`else

`define IMO_ASSERT(lbl, prop)
`define IMO_ASSERT_NEVER(lbl, cond)

`endif

`endif

### design/imo_pkg.sv
// shared types and constants for the interval overlap block
`default_nettype none

package imo_pkg;

  localparam int TIME_SLOTS_DEF    = 1024;
  localparam int MAX_INTERVALS_DEF = 1024;

  localparam int OUT_W   = 11;
  localparam int OUT_MAX = 2047;

  localparam logic [0:0] CMD_ADD    = 1'b0;
  localparam logic [0:0] CMD_REPORT = 1'b1;

  // operation carried down the chain of cells
  typedef enum logic [1:0] {
    OP_NONE   = 2'b00,
    OP_ADD    = 2'b01,
    OP_REPORT = 2'b10
  } op_e;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [9:0]  start_time;
    logic [10:0] end_time;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] interval_count;
    logic [OUT_W-1:0] max_overlap;
  } out_t;

endpackage

`default_nettype wire

### design/imo_cell.sv
// one time slot of the difference store, with its stage of the request chain
`default_nettype none

module imo_cell import imo_pkg::*; #(
  parameter int TW   = 11,
  parameter int CW   = 11,
  parameter int SLOT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  op_e              op_i,
  input  logic [TW-1:0]    start_i,
  input  logic [TW-1:0]    end_i,
  input  logic [CW-1:0]    run_i,
  input  logic [CW-1:0]    best_i,
  input  logic [OUT_W-1:0] cnt_i,
  output op_e              op_o,
  output logic [TW-1:0]    start_o,
  output logic [TW-1:0]    end_o,
  output logic [CW-1:0]    run_o,
  output logic [CW-1:0]    best_o,
  output logic [OUT_W-1:0] cnt_o
);

  logic signed [CW:0] delta_q, delta_d;
  logic signed [CW:0] run_sum;
  logic [CW-1:0]      run_new, best_new;
  logic               hit_start, hit_end;

  op_e              op_q;
  logic [TW-1:0]    start_q, end_q;
  logic [CW-1:0]    run_q, best_q;
  logic [OUT_W-1:0] cnt_q;

  always_comb begin
    hit_start = (start_i == TW'(SLOT));
    hit_end   = (end_i == TW'(SLOT));
    // running coverage never goes negative, so the low bits hold it
    run_sum   = $signed({1'b0, run_i}) + delta_q;
    run_new   = run_sum[CW-1:0];
    best_new  = (run_new > best_i) ? run_new : best_i;
    delta_d   = delta_q;
    unique case (op_i)
      OP_ADD: begin
        if (hit_start) begin
          delta_d = delta_q + (CW+1)'(1);
        end else if (hit_end) begin
          delta_d = delta_q - (CW+1)'(1);
        end
      end
      OP_REPORT: begin
        delta_d = '0;
      end
      default: begin
        delta_d = delta_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
      op_q    <= OP_NONE;
    end else if (adv_i) begin
      delta_q <= delta_d;
      op_q    <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      start_q <= start_i;
      end_q   <= end_i;
      run_q   <= (op_i == OP_REPORT) ? run_new : run_i;
      best_q  <= (op_i == OP_REPORT) ? best_new : best_i;
      cnt_q   <= cnt_i;
    end
  end

  assign op_o    = op_q;
  assign start_o = start_q;
  assign end_o   = end_q;
  assign run_o   = run_q;
  assign best_o  = best_q;
  assign cnt_o   = cnt_q;

endmodule

`default_nettype wire

### design/interval_max_overlap.sv
// top level: interval overlap counter built as a chain of slot cells
`default_nettype none

// Maximum overlap of half-open intervals [start_time, end_time). Each request
// enters a chain of TIME_SLOTS cells, one cell per time slot, and moves one
// cell per cycle while the chain advances; the block takes a new request every
// cycle unless a report at the end of the chain meets a full output register
// that is not being read. An add request changes the cells of its start and
// end slots as it passes. A report request sums the slots on its way down the
// chain, tracking the running maximum and clearing each cell behind it; its
// result is registered at the output as it leaves the last cell. Add requests
// give no result; those past MAX_INTERVALS since the last report are dropped.
// The store is cleared by reset directly; no clearing pass is needed.
module interval_max_overlap import imo_pkg::*; #(
  parameter int TIME_SLOTS    = TIME_SLOTS_DEF,
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  `include "interval_max_overlap_defines.svh"

  localparam int TW = $clog2(TIME_SLOTS + 1);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int IW = (TW > 11) ? TW : 11;
  localparam int SW = (CW > OUT_W) ? CW : OUT_W;

  op_e              op_c    [TIME_SLOTS+1];
  logic [TW-1:0]    start_c [TIME_SLOTS+1];
  logic [TW-1:0]    end_c   [TIME_SLOTS+1];
  logic [CW-1:0]    run_c   [TIME_SLOTS+1];
  logic [CW-1:0]    best_c  [TIME_SLOTS+1];
  logic [OUT_W-1:0] cnt_c   [TIME_SLOTS+1];

  logic          adv, acc, is_rep, counted, nonempty, tail_rep;
  logic [IW-1:0] s_ext, e_ext, e_clamp;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q;
  op_e           op_in;

  // whole chain stalls only when a report reaches a full output register that is not being read
  assign tail_rep   = (op_c[TIME_SLOTS] == OP_REPORT);
  assign adv        = !(tail_rep && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  always_comb begin
    is_rep   = (in_data_i.cmd == CMD_REPORT);
    counted  = (cnt_q < CW'(MAX_INTERVALS));
    s_ext    = IW'(in_data_i.start_time);
    e_ext    = IW'(in_data_i.end_time);
    e_clamp  = (e_ext > IW'(TIME_SLOTS)) ? IW'(TIME_SLOTS) : e_ext;
    nonempty = (e_clamp > s_ext);

    op_in = OP_NONE;
    if (acc) begin
      if (is_rep) begin
        op_in = OP_REPORT;
      end else if (counted && nonempty) begin
        op_in = OP_ADD;
      end
    end

    cnt_d = cnt_q;
    if (acc) begin
      if (is_rep) begin
        cnt_d = '0;
      end else if (counted) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  assign op_c[0]    = op_in;
  assign start_c[0] = TW'(s_ext);
  assign end_c[0]   = TW'(e_clamp);
  assign run_c[0]   = '0;
  assign best_c[0]  = '0;
  assign cnt_c[0]   = (SW'(cnt_q) > SW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(cnt_q);

  for (genvar i = 0; i < TIME_SLOTS; i++) begin : g_cell
    imo_cell #(
      .TW   (TW),
      .CW   (CW),
      .SLOT (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .op_i    (op_c[i]),
      .start_i (start_c[i]),
      .end_i   (end_c[i]),
      .run_i   (run_c[i]),
      .best_i  (best_c[i]),
      .cnt_i   (cnt_c[i]),
      .op_o    (op_c[i+1]),
      .start_o (start_c[i+1]),
      .end_o   (end_c[i+1]),
      .run_o   (run_c[i+1]),
      .best_o  (best_c[i+1]),
      .cnt_o   (cnt_c[i+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && tail_rep) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_rep) begin
      out_q.interval_count <= cnt_c[TIME_SLOTS];
      out_q.max_overlap    <= (SW'(best_c[TIME_SLOTS]) > SW'(OUT_MAX)) ?
                              OUT_W'(OUT_MAX) : OUT_W'(best_c[TIME_SLOTS]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IMO_ASSERT(a_stall_only_on_full_out, !in_ready_o |-> (out_valid_o && !out_ready_i))
  `IMO_ASSERT(a_report_lands, (adv && tail_rep) |=> out_valid_o)
  `IMO_ASSERT_NEVER(a_cnt_bound, cnt_q > CW'(MAX_INTERVALS))
  `IMO_ASSERT(a_overlap_le_count,
              out_valid_o |-> (out_data_o.max_overlap <= out_data_o.interval_count))

endmodule

`default_nettype wire

### tb/tb_interval_max_overlap.sv
// self-checking testbench for the interval overlap block, with its own prediction of every report
module tb_interval_max_overlap;
  timeunit 1ns;
  timeprecision 1ps;

  import imo_pkg::*;

  localparam int TIME_SLOTS     = TIME_SLOTS_DEF;
  localparam int MAX_INTERVALS  = MAX_INTERVALS_DEF;
  localparam int REPORT_LATENCY = TIME_SLOTS + 1;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  interval_max_overlap #(
    .TIME_SLOTS   (TIME_SLOTS),
    .MAX_INTERVALS(MAX_INTERVALS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // overlap predictor state
  int   slot_diff [0:TIME_SLOTS];
  int   adds_counted;
  out_t expected_reports [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int reports_sent   = 0;
  int reports_checked = 0;
  int idle_cycles    = 0;
  out_t oldest_report;

  function automatic logic [OUT_W-1:0] clip_out(input int v);
    return (v > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
  endfunction

  function automatic void clear_overlap_state();
    foreach (slot_diff[i]) slot_diff[i] = 0;
    adds_counted = 0;
  endfunction

  // update the predictor with one accepted request
  function automatic void track_request(input in_t req);
    int   stop;
    int   run;
    int   best;
    out_t res;
    if (req.cmd == CMD_ADD) begin
      if (adds_counted < MAX_INTERVALS) begin
        adds_counted++;
        stop = (int'(req.end_time) > TIME_SLOTS) ? TIME_SLOTS : int'(req.end_time);
        if (stop > int'(req.start_time)) begin
          slot_diff[req.start_time] += 1;
          slot_diff[stop] -= 1;
        end
      end
    end else begin
      run  = 0;
      best = 0;
      for (int t = 0; t < TIME_SLOTS; t++) begin
        run += slot_diff[t];
        if (run > best) best = run;
      end
      res.interval_count = clip_out(adds_counted);
      res.max_overlap    = clip_out(best);
      expected_reports.push_back(res);
      clear_overlap_state();
    end
  endfunction

  function automatic in_t make_req(input logic [0:0] cmd, input int s, input int e);
    in_t r;
    r.cmd        = cmd;
    r.start_time = s[9:0];
    r.end_time   = e[10:0];
    return r;
  endfunction

  // random add, often piled up around one hot slot to build deep overlap
  function automatic in_t random_add(input int hot);
    int mode;
    int s;
    int e;
    mode = $urandom_range(9);
    s    = $urandom_range(1023);
    e    = $urandom_range(TIME_SLOTS);
    if (mode >= 4 && mode <= 6) begin
      s = (hot > 20) ? hot - $urandom_range(20) : $urandom_range(hot);
      e = hot + 1 + $urandom_range(20);
      if (e > TIME_SLOTS) e = TIME_SLOTS;
    end else if (mode == 7) begin
      e = TIME_SLOTS;
    end else if (mode == 8) begin
      e = $urandom_range(s);
    end else if (mode == 9) begin
      e = s + 1;
    end
    return make_req(CMD_ADD, s, e);
  endfunction

  // valid stays high after an accept unless the next call idles
  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    track_request(req);
    requests_sent++;
    if (req.cmd == CMD_REPORT) reports_sent++;
  endtask

  task automatic send_report();
    send_request(make_req(CMD_REPORT, $urandom_range(1023), $urandom_range(2047)));
  endtask

  task automatic wait_reports_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic test_directed();
    send_request(make_req(CMD_REPORT, 1023, 2047));
    send_request(make_req(CMD_ADD, 0, 1024));
    send_request(make_req(CMD_ADD, 1023, 1024));
    send_request(make_req(CMD_ADD, 0, 1));
    send_request(make_req(CMD_ADD, 5, 5));
    send_request(make_req(CMD_ADD, 10, 3));
    send_request(make_req(CMD_ADD, 1023, 0));
    // ends past the last slot get clamped
    send_request(make_req(CMD_ADD, 100, 2047));
    send_request(make_req(CMD_ADD, 200, 1500));
    send_request(make_req(CMD_ADD, 0, 1024));
    send_request(make_req(CMD_REPORT, 0, 0));
    send_request(make_req(CMD_REPORT, 682, 1365));
    send_request(make_req(CMD_ADD, 682, 683));
    send_request(make_req(CMD_ADD, 341, 1023));
    send_request(make_req(CMD_ADD, 512, 1024));
    send_request(make_req(CMD_ADD, 1022, 1023));
    send_request(make_req(CMD_REPORT, 341, 682));
    wait_reports_drained();
  endtask

  // more adds than the counter holds; the extra ones must be dropped
  task automatic test_counter_full();
    repeat (MAX_INTERVALS + 6) begin
      send_request(make_req(CMD_ADD, $urandom_range(500), 501 + $urandom_range(523)));
    end
    send_report();
    send_request(make_req(CMD_ADD, 7, 9));
    send_report();
  endtask

  task automatic test_random_groups(input int n_items);
    int sent;
    int group_len;
    int kind;
    int hot;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(19);
      hot  = $urandom_range(1023);
      if (kind == 0) begin
        send_report();
        sent++;
      end else begin
        group_len = (kind < 17) ? 1 + $urandom_range(29) : 1 + $urandom_range(3);
        repeat (group_len) begin
          send_request(random_add(hot));
          sent++;
        end
        send_report();
        sent++;
        if ($urandom_range(9) == 0) wait_reports_drained();
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none pending: count=%0d overlap=%0d", $time,
                 out_data_o.interval_count, out_data_o.max_overlap);
        mismatches++;
      end else begin
        oldest_report = expected_reports.pop_front();
        reports_checked++;
        if (out_data_o.interval_count !== oldest_report.interval_count) begin
          $display("%0t: interval_count expected %0d actual %0d", $time,
                   oldest_report.interval_count, out_data_o.interval_count);
          mismatches++;
        end
        if (out_data_o.max_overlap !== oldest_report.max_overlap) begin
          $display("%0t: max_overlap expected %0d actual %0d", $time,
                   oldest_report.max_overlap, out_data_o.max_overlap);
          mismatches++;
        end
      end
    end
  end

  // cycles with no accept on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results pending", $time,
               idle_cycles, expected_reports.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_overlap_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 13;
    recv_stall_pct = 63;
    test_directed();
    test_random_groups(300);

    send_idle_pct  = 63;
    recv_stall_pct = 13;
    test_random_groups(300);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_counter_full();
    test_random_groups(300);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
    repeat (REPORT_LATENCY + 50) @(posedge clk_i);

    foreach (expected_reports[i]) begin
      $display("%0t: missing result: count=%0d overlap=%0d", $time,
               expected_reports[i].interval_count, expected_reports[i].max_overlap);
      mismatches++;
    end
    $display("sent %0d requests with %0d reports, checked %0d results, %0d mismatches",
             requests_sent, reports_sent, reports_checked, mismatches);
    $display("covered clamped and empty intervals, a full interval counter and three stall mixes");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### interval_max_overlap.f
+incdir+design
design/imo_pkg.sv
design/imo_cell.sv
design/interval_max_overlap.sv
tb/tb_interval_max_overlap.sv
